// ===== rtl/bdmc_pkg.sv =====
// bdmc_pkg: shared types, constants and helper functions for the descriptor match classifier
// no dependencies; used by every rtl file through scoped names
`timescale 1ns / 1ps

package bdmc_pkg;

  localparam int DESC_BITS  = 256;
  localparam int WORD_W     = 64;
  localparam int NUM_WORDS  = 4;
  localparam int PCNT_W     = $clog2(WORD_W + 1);
  localparam int DIST_W     = 9;
  localparam int ID_BITS    = 20;
  localparam int TID_W      = ID_BITS + 1;
  localparam int CFG_W      = 20;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  localparam logic [DIST_W-1:0]  LIMIT_RESET = DIST_W'(64);
  localparam logic [ID_BITS-1:0] ID_MAX      = {ID_BITS{1'b1}};
  localparam logic [TID_W-1:0]   ID_INVALID  = {TID_W{1'b1}};

  // item modes
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_CAND  = 1'b1;

  // configuration register indexes
  localparam logic CFG_DISTANCE_LIMIT = 1'b0;
  localparam logic CFG_NEW_ID_BASE    = 1'b1;

  typedef enum logic [2:0] {
    KIND_TRACKED  = 3'd0,
    KIND_FEATURE  = 3'd1,
    KIND_NEW      = 3'd2,
    KIND_NO_CLOSE = 3'd3,
    KIND_NO_DEPTH = 3'd4
  } kind_t;

  // one classified word handed from front to back
  typedef struct packed {
    logic                             mode;
    logic [NUM_WORDS-1:0][PCNT_W-1:0] pcnt;
    logic [ID_BITS-1:0]               model_index;
    logic                             depth_valid;
    logic [TID_W-1:0]                 trk_id;
    logic                             frame_first;
    logic                             last;
  } cls_item_t;

  // bits of descriptor word w that lie below DESC_BITS
  function automatic logic [WORD_W-1:0] word_mask(input int w);
    logic [WORD_W-1:0] m;
    int n;
    n = DESC_BITS - WORD_W * w;
    if (n >= WORD_W) begin
      m = {WORD_W{1'b1}};
    end else if (n <= 0) begin
      m = '0;
    end else begin
      m = (WORD_W'(1) << n) - WORD_W'(1);
    end
    return m;
  endfunction

  // swar population count of a 64-bit word
  function automatic logic [PCNT_W-1:0] popcount64(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] v1, v2, v3, v4, v5, v6;
    v1 = v - ((v >> 1) & 64'h5555_5555_5555_5555);
    v2 = (v1 & 64'h3333_3333_3333_3333) + ((v1 >> 2) & 64'h3333_3333_3333_3333);
    v3 = (v2 + (v2 >> 4)) & 64'h0F0F_0F0F_0F0F_0F0F;
    v4 = v3 + (v3 >> 8);
    v5 = v4 + (v4 >> 16);
    v6 = v5 + (v5 >> 32);
    return v6[PCNT_W-1:0];
  endfunction

endpackage

// ===== rtl/binary_descriptor_match_classifier_top.sv =====
// binary_descriptor_match_classifier_top: 256-bit hamming nearest-neighbor keypoint classifier
// depends on bdmc_pkg, bdmc_front, bdmc_queue, bdmc_back
`timescale 1ns / 1ps

//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------------
//  in_     | in        | in_valid / in_stall | mode, desc_word0..3, model_index,
//          |           |                     | depth_valid, tracked_id, frame_first, last
//  out_    | out       | out_valid/out_stall | match_id, match_kind, best_distance
//  cfg_    | in        | cfg_we              | cfg_index, cfg_wdata
//
//  one input word per cycle while the queue has room; the front does the xor and four 64-bit
//  popcounts on the word as it is taken, the back sums them and compares combinationally
//  a result passes through a queue slot and then the result register before it shows on out_
//  synchronous active-low reset, no clearing pass; the block is ready the cycle after reset
//  out_stall holds the result register; the four-word queue keeps taking input until it fills,
//  and words without last keep draining while a result waits

module binary_descriptor_match_classifier_top (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration write port
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [bdmc_pkg::CFG_W-1:0]         cfg_wdata,
  // input words
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_mode,
  input  logic [bdmc_pkg::WORD_W-1:0]        in_desc_word0,
  input  logic [bdmc_pkg::WORD_W-1:0]        in_desc_word1,
  input  logic [bdmc_pkg::WORD_W-1:0]        in_desc_word2,
  input  logic [bdmc_pkg::WORD_W-1:0]        in_desc_word3,
  input  logic [bdmc_pkg::ID_BITS-1:0]       in_model_index,
  input  logic                               in_depth_valid,
  input  logic signed [bdmc_pkg::TID_W-1:0]  in_tracked_id,
  input  logic                               in_frame_first,
  input  logic                               in_last,
  // result words
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [bdmc_pkg::TID_W-1:0]  out_match_id,
  output logic [2:0]                         out_match_kind,
  output logic [bdmc_pkg::DIST_W-1:0]        out_best_distance
);

  // front to queue
  logic                push_valid;
  logic                push_ready;
  bdmc_pkg::cls_item_t push_item;

  // queue to back
  logic                pop_valid;
  logic                pop_en;
  bdmc_pkg::cls_item_t pop_item;

  // input is held off only when the queue is full
  assign in_stall = !push_ready;

  // query descriptor register and per-word distance popcounts
  bdmc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_mode        (in_mode),
    .in_desc_word0  (in_desc_word0),
    .in_desc_word1  (in_desc_word1),
    .in_desc_word2  (in_desc_word2),
    .in_desc_word3  (in_desc_word3),
    .in_model_index (in_model_index),
    .in_depth_valid (in_depth_valid),
    .in_tracked_id  (in_tracked_id),
    .in_frame_first (in_frame_first),
    .in_last        (in_last),
    .push_ready     (push_ready),
    .push_valid     (push_valid),
    .push_item      (push_item)
  );

  // decoupling queue so the front keeps going while a result is stalled
  bdmc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_en     (pop_en),
    .pop_item   (pop_item)
  );

  // best-match state, classification and output register
  bdmc_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .pop_valid         (pop_valid),
    .pop_en            (pop_en),
    .pop_item          (pop_item),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_match_id      (out_match_id),
    .out_match_kind    (out_match_kind),
    .out_best_distance (out_best_distance)
  );

endmodule

// ===== rtl/bdmc_front.sv =====
// bdmc_front: holds the query descriptor and turns each input word into a classified word
// depends on bdmc_pkg
`timescale 1ns / 1ps

module bdmc_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_mode,
  input  logic [bdmc_pkg::WORD_W-1:0]       in_desc_word0,
  input  logic [bdmc_pkg::WORD_W-1:0]       in_desc_word1,
  input  logic [bdmc_pkg::WORD_W-1:0]       in_desc_word2,
  input  logic [bdmc_pkg::WORD_W-1:0]       in_desc_word3,
  input  logic [bdmc_pkg::ID_BITS-1:0]      in_model_index,
  input  logic                              in_depth_valid,
  input  logic [bdmc_pkg::TID_W-1:0]        in_tracked_id,
  input  logic                              in_frame_first,
  input  logic                              in_last,
  input  logic                              push_ready,
  output logic                              push_valid,
  output bdmc_pkg::cls_item_t               push_item
);

  logic [bdmc_pkg::NUM_WORDS-1:0][bdmc_pkg::WORD_W-1:0] query_r;
  logic [bdmc_pkg::NUM_WORDS-1:0][bdmc_pkg::WORD_W-1:0] query_nxt;
  logic [bdmc_pkg::NUM_WORDS-1:0][bdmc_pkg::WORD_W-1:0] cand;
  logic                                                 accept;

  assign cand       = {in_desc_word3, in_desc_word2, in_desc_word1, in_desc_word0};
  assign accept     = in_valid && push_ready;
  assign push_valid = in_valid;

  always_comb begin
    query_nxt = query_r;
    if (accept && (in_mode == bdmc_pkg::MODE_START)) begin
      query_nxt = cand;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      query_r <= '0;
    end else begin
      query_r <= query_nxt;
    end
  end

  always_comb begin
    push_item.mode        = in_mode;
    push_item.model_index = in_model_index;
    push_item.depth_valid = in_depth_valid;
    push_item.trk_id      = in_tracked_id;
    push_item.frame_first = in_frame_first;
    push_item.last        = in_last;
    for (int w = 0; w < bdmc_pkg::NUM_WORDS; w++) begin
      push_item.pcnt[w] = bdmc_pkg::popcount64((cand[w] ^ query_r[w]) & bdmc_pkg::word_mask(w));
    end
  end

endmodule

// ===== rtl/bdmc_queue.sv =====
// bdmc_queue: short register queue of classified words between front and back
// depends on bdmc_pkg
`timescale 1ns / 1ps

module bdmc_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  bdmc_pkg::cls_item_t push_item,
  output logic                pop_valid,
  input  logic                pop_en,
  output bdmc_pkg::cls_item_t pop_item
);

  bdmc_pkg::cls_item_t               slot_r [bdmc_pkg::QDEPTH];
  logic [bdmc_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [bdmc_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [bdmc_pkg::QCNT_W-1:0]       count_r, count_nxt;
  logic                              do_push, do_pop;

  assign push_ready = (count_r != bdmc_pkg::QCNT_W'(bdmc_pkg::QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_en && pop_valid;
  assign pop_item   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== rtl/bdmc_back.sv =====
// bdmc_back: best-match tracking, id counter, configuration registers and result register
// depends on bdmc_pkg
`timescale 1ns / 1ps

module bdmc_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [bdmc_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic                             pop_valid,
  output logic                             pop_en,
  input  bdmc_pkg::cls_item_t              pop_item,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [bdmc_pkg::TID_W-1:0] out_match_id,
  output logic [2:0]                       out_match_kind,
  output logic [bdmc_pkg::DIST_W-1:0]      out_best_distance
);

  logic [bdmc_pkg::DIST_W-1:0]  limit_r;
  logic [bdmc_pkg::ID_BITS-1:0] id_base_r;

  logic [bdmc_pkg::DIST_W-1:0]  best_dist_r, best_dist_nxt;
  logic [bdmc_pkg::ID_BITS-1:0] best_model_r, best_model_nxt;
  logic                         found_r, found_nxt;
  logic                         seen_r, seen_nxt;
  logic                         depth_ok_r, depth_ok_nxt;
  logic [bdmc_pkg::TID_W-1:0]   tracked_r, tracked_nxt;
  logic [bdmc_pkg::ID_BITS-1:0] next_id_r, next_id_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [bdmc_pkg::TID_W-1:0]   out_id_r, out_id_nxt;
  bdmc_pkg::kind_t              out_kind_r, out_kind_nxt;
  logic [bdmc_pkg::DIST_W-1:0]  out_dist_r, out_dist_nxt;

  logic                         out_free;
  logic [bdmc_pkg::DIST_W-1:0]  ham_dist;

  assign out_free = !out_valid_r || !out_stall;
  // a word without last can always retire; a last word needs the result slot
  assign pop_en   = pop_valid && (!pop_item.last || out_free);

  always_comb begin
    ham_dist = '0;
    for (int w = 0; w < bdmc_pkg::NUM_WORDS; w++) begin
      ham_dist = ham_dist + bdmc_pkg::DIST_W'(pop_item.pcnt[w]);
    end
  end

  always_comb begin
    best_dist_nxt  = best_dist_r;
    best_model_nxt = best_model_r;
    found_nxt      = found_r;
    seen_nxt       = seen_r;
    depth_ok_nxt   = depth_ok_r;
    tracked_nxt    = tracked_r;
    next_id_nxt    = next_id_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_id_nxt     = out_id_r;
    out_kind_nxt   = out_kind_r;
    out_dist_nxt   = out_dist_r;

    if (pop_en) begin
      if (pop_item.mode == bdmc_pkg::MODE_START) begin
        if (pop_item.frame_first) begin
          next_id_nxt = id_base_r;
        end
        depth_ok_nxt   = pop_item.depth_valid;
        tracked_nxt    = pop_item.trk_id;
        best_dist_nxt  = limit_r;
        best_model_nxt = '0;
        found_nxt      = 1'b0;
        seen_nxt       = 1'b0;
      end else begin
        seen_nxt = 1'b1;
        if (ham_dist < best_dist_r) begin
          best_dist_nxt  = ham_dist;
          best_model_nxt = pop_item.model_index;
          found_nxt      = 1'b1;
        end
      end

      if (pop_item.last) begin
        out_valid_nxt = 1'b1;
        out_dist_nxt  = best_dist_nxt;
        if (!depth_ok_nxt) begin
          out_id_nxt   = bdmc_pkg::ID_INVALID;
          out_kind_nxt = bdmc_pkg::KIND_NO_DEPTH;
        end else if (!tracked_nxt[bdmc_pkg::TID_W-1]) begin
          out_id_nxt   = tracked_nxt;
          out_kind_nxt = bdmc_pkg::KIND_TRACKED;
        end else if (found_nxt) begin
          out_id_nxt   = {1'b0, best_model_nxt};
          out_kind_nxt = bdmc_pkg::KIND_FEATURE;
        end else if (!seen_nxt) begin
          out_id_nxt   = {1'b0, next_id_nxt};
          out_kind_nxt = bdmc_pkg::KIND_NEW;
          // saturating fresh id counter
          if (next_id_nxt != bdmc_pkg::ID_MAX) begin
            next_id_nxt = next_id_nxt + 1'b1;
          end
        end else begin
          out_id_nxt   = bdmc_pkg::ID_INVALID;
          out_kind_nxt = bdmc_pkg::KIND_NO_CLOSE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r   <= bdmc_pkg::LIMIT_RESET;
      id_base_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == bdmc_pkg::CFG_DISTANCE_LIMIT) begin
        limit_r <= cfg_wdata[bdmc_pkg::DIST_W-1:0];
      end else begin
        id_base_r <= cfg_wdata[bdmc_pkg::ID_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_dist_r  <= bdmc_pkg::LIMIT_RESET;
      best_model_r <= '0;
      found_r      <= 1'b0;
      seen_r       <= 1'b0;
      depth_ok_r   <= 1'b0;
      tracked_r    <= bdmc_pkg::ID_INVALID;
      next_id_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      best_dist_r  <= best_dist_nxt;
      best_model_r <= best_model_nxt;
      found_r      <= found_nxt;
      seen_r       <= seen_nxt;
      depth_ok_r   <= depth_ok_nxt;
      tracked_r    <= tracked_nxt;
      next_id_r    <= next_id_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_id_r   <= out_id_nxt;
    out_kind_r <= out_kind_nxt;
    out_dist_r <= out_dist_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_match_id      = $signed(out_id_r);
  assign out_match_kind    = out_kind_r;
  assign out_best_distance = out_dist_r;

endmodule

// ===== rtl/bdmc_checker.sv =====
// bdmc_checker: port-level assertions for the classifier top, attached by bind
// depends on bdmc_pkg and binary_descriptor_match_classifier_top
`timescale 1ns / 1ps

module bdmc_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [bdmc_pkg::TID_W-1:0]  out_match_id,
  input logic [2:0]                         out_match_kind,
  input logic [bdmc_pkg::DIST_W-1:0]        out_best_distance
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_match_id) &&
      $stable(out_match_kind) && $stable(out_best_distance))
    else $error("stalled result changed");

  // invalid kinds carry the invalid id
  a_invalid_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_match_kind == bdmc_pkg::KIND_NO_DEPTH ||
      out_match_kind == bdmc_pkg::KIND_NO_CLOSE) |-> out_match_id == -1)
    else $error("invalid kind with a real id");

  // valid kinds carry a non-negative id
  a_valid_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_match_kind == bdmc_pkg::KIND_TRACKED ||
      out_match_kind == bdmc_pkg::KIND_FEATURE || out_match_kind == bdmc_pkg::KIND_NEW)
      |-> !out_match_id[bdmc_pkg::TID_W-1])
    else $error("valid kind with negative id");

  // a feature match never reports a distance above the descriptor width
  a_feature_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_match_kind == bdmc_pkg::KIND_FEATURE |->
      out_best_distance <= bdmc_pkg::DIST_W'(bdmc_pkg::DESC_BITS))
    else $error("feature match distance out of range");

  // reset empties the result register
  a_reset_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind binary_descriptor_match_classifier_top bdmc_checker u_bdmc_checker (.*);
